FILE: hw/rtl/aabb_pkg.sv
// ----------------------------------------------------------------------------
// aabb_pkg
// Shared types and constants for the bounding box and sphere block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aabb_pkg;

  // entries in the job queue between the front and the back
  localparam int unsigned JOB_QUEUE_DEPTH = 2;

  // sphere finish sequencer
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SQUARE,
    BK_ROOT,
    BK_OUT
  } bk_state_e;

endpackage

FILE: hw/rtl/aabb_if.sv
// ----------------------------------------------------------------------------
// aabb_if
// Valid/ready channels for vertex beats and mesh result beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface aabb_vtx_if #(
  parameter int unsigned W = 24
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] pos_x;
  logic signed [W-1:0] pos_y;
  logic signed [W-1:0] pos_z;
  logic                last_vertex;

  modport source (output valid, pos_x, pos_y, pos_z, last_vertex, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, last_vertex, output ready);
endinterface

interface aabb_res_if #(
  parameter int unsigned W = 24
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] min_x;
  logic signed [W-1:0] min_y;
  logic signed [W-1:0] min_z;
  logic signed [W-1:0] max_x;
  logic signed [W-1:0] max_y;
  logic signed [W-1:0] max_z;
  logic signed [W-1:0] center_x;
  logic signed [W-1:0] center_y;
  logic signed [W-1:0] center_z;
  logic        [W-1:0] radius;

  modport source (output valid, min_x, min_y, min_z, max_x, max_y, max_z,
                  center_x, center_y, center_z, radius, input ready);
  modport sink   (input valid, min_x, min_y, min_z, max_x, max_y, max_z,
                  center_x, center_y, center_z, radius, output ready);
endinterface

FILE: hw/rtl/aabb_front.sv
// ----------------------------------------------------------------------------
// aabb_front
// Takes vertex beats, tracks the running box, hands finished boxes on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aabb_front #(
  parameter int unsigned W = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  aabb_vtx_if.sink         vtx_i,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output logic [6*W-1:0]   push_data_o
);
  import aabb_pkg::*;

  logic                first_q;
  logic signed [W-1:0] min_x_q, min_y_q, min_z_q;
  logic signed [W-1:0] max_x_q, max_y_q, max_z_q;
  logic signed [W-1:0] min_x_d, min_y_d, min_z_d;
  logic signed [W-1:0] max_x_d, max_y_d, max_z_d;
  logic                acc_beat;

  assign vtx_i.ready = push_ready_i;
  assign acc_beat    = vtx_i.valid && vtx_i.ready;

  always_comb begin
    if (first_q) begin
      min_x_d = vtx_i.pos_x;
      min_y_d = vtx_i.pos_y;
      min_z_d = vtx_i.pos_z;
      max_x_d = vtx_i.pos_x;
      max_y_d = vtx_i.pos_y;
      max_z_d = vtx_i.pos_z;
    end else begin
      min_x_d = (vtx_i.pos_x < min_x_q) ? vtx_i.pos_x : min_x_q;
      min_y_d = (vtx_i.pos_y < min_y_q) ? vtx_i.pos_y : min_y_q;
      min_z_d = (vtx_i.pos_z < min_z_q) ? vtx_i.pos_z : min_z_q;
      max_x_d = (vtx_i.pos_x > max_x_q) ? vtx_i.pos_x : max_x_q;
      max_y_d = (vtx_i.pos_y > max_y_q) ? vtx_i.pos_y : max_y_q;
      max_z_d = (vtx_i.pos_z > max_z_q) ? vtx_i.pos_z : max_z_q;
    end
  end

  // a last vertex closes the mesh and pushes its box
  assign push_valid_o = acc_beat && vtx_i.last_vertex;
  assign push_data_o  = {min_x_d, min_y_d, min_z_d, max_x_d, max_y_d, max_z_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
      min_x_q <= '0;
      min_y_q <= '0;
      min_z_q <= '0;
      max_x_q <= '0;
      max_y_q <= '0;
      max_z_q <= '0;
    end else if (acc_beat) begin
      first_q <= vtx_i.last_vertex;
      min_x_q <= min_x_d;
      min_y_q <= min_y_d;
      min_z_q <= min_z_d;
      max_x_q <= max_x_d;
      max_y_q <= max_y_d;
      max_z_q <= max_z_d;
    end
  end

endmodule

FILE: hw/rtl/aabb_queue.sv
// ----------------------------------------------------------------------------
// aabb_queue
// Small first-in first-out queue of finished boxes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aabb_queue #(
  parameter int unsigned DATA_W = 144,
  parameter int unsigned DEPTH  = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output logic [DATA_W-1:0] pop_data_o
);
  import aabb_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign push_ready_o = (cnt_q != CntW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/aabb_back.sv
// ----------------------------------------------------------------------------
// aabb_back
// Finishes one box: centre, sum of squared extents, square root, result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aabb_back #(
  parameter int unsigned W = 24
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  output logic           job_pop_o,
  input  logic [6*W-1:0] job_data_i,
  aabb_res_if.source     res_o
);
  import aabb_pkg::*;

  localparam int unsigned R     = W + 1;       // root bits
  localparam int unsigned AccW  = 2 * R;       // sum of three squares
  localparam int unsigned RemW  = R + 3;
  localparam int unsigned RcntW = $clog2(R);

  bk_state_e state_q, state_d;

  logic signed [W-1:0] j_min_x, j_min_y, j_min_z, j_max_x, j_max_y, j_max_z;
  logic signed [W-1:0] min_x_q, min_y_q, min_z_q, max_x_q, max_y_q, max_z_q;
  logic signed [W-1:0] cen_x_q, cen_y_q, cen_z_q;
  logic signed [W:0]   sum_x, sum_y, sum_z, dif_x, dif_y, dif_z;
  logic [W-1:0]        dx_q, dy_q, dz_q, d_sel;
  logic [2*W-1:0]      prod_q;
  logic [AccW-1:0]     acc_q;
  logic [RemW-1:0]     rem_q, rem_sh, trial, rem_d;
  logic [R-1:0]        root_q, root_d;
  logic [1:0]          sq_cnt_q;
  logic [RcntW-1:0]    root_cnt_q;
  logic                load;

  assign {j_min_x, j_min_y, j_min_z, j_max_x, j_max_y, j_max_z} = job_data_i;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    job_pop_o = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          state_d   = BK_SQUARE;
        end
      end
      BK_SQUARE: begin
        if (sq_cnt_q == 2'd3) state_d = BK_ROOT;
      end
      BK_ROOT: begin
        if (root_cnt_q == '0) state_d = BK_OUT;
      end
      BK_OUT: begin
        if (res_o.ready) state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  assign load = job_pop_o;

  // centre and extents at load
  assign sum_x = {j_min_x[W-1], j_min_x} + {j_max_x[W-1], j_max_x};
  assign sum_y = {j_min_y[W-1], j_min_y} + {j_max_y[W-1], j_max_y};
  assign sum_z = {j_min_z[W-1], j_min_z} + {j_max_z[W-1], j_max_z};
  assign dif_x = {j_max_x[W-1], j_max_x} - {j_min_x[W-1], j_min_x};
  assign dif_y = {j_max_y[W-1], j_max_y} - {j_min_y[W-1], j_min_y};
  assign dif_z = {j_max_z[W-1], j_max_z} - {j_min_z[W-1], j_min_z};

  always_comb begin
    unique case (sq_cnt_q)
      2'd0:    d_sel = dx_q;
      2'd1:    d_sel = dy_q;
      default: d_sel = dz_q;
    endcase
  end

  // one root bit per cycle, two radicand bits shifted in
  always_comb begin
    rem_sh = {rem_q[RemW-3:0], acc_q[AccW-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    if (rem_sh >= trial) begin
      rem_d  = rem_sh - trial;
      root_d = {root_q[R-2:0], 1'b1};
    end else begin
      rem_d  = rem_sh;
      root_d = {root_q[R-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_cnt_q   <= '0;
      root_cnt_q <= '0;
    end else if (load) begin
      sq_cnt_q   <= '0;
      root_cnt_q <= RcntW'(R - 1);
    end else if (state_q == BK_SQUARE) begin
      sq_cnt_q <= sq_cnt_q + 1'b1;
    end else if (state_q == BK_ROOT) begin
      root_cnt_q <= root_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      min_x_q <= j_min_x;
      min_y_q <= j_min_y;
      min_z_q <= j_min_z;
      max_x_q <= j_max_x;
      max_y_q <= j_max_y;
      max_z_q <= j_max_z;
      cen_x_q <= sum_x[W:1];
      cen_y_q <= sum_y[W:1];
      cen_z_q <= sum_z[W:1];
      dx_q    <= dif_x[W-1:0];
      dy_q    <= dif_y[W-1:0];
      dz_q    <= dif_z[W-1:0];
      acc_q   <= '0;
      rem_q   <= '0;
      root_q  <= '0;
    end else if (state_q == BK_SQUARE) begin
      prod_q <= d_sel * d_sel;
      // product of the previous axis is added in the following cycle
      if (sq_cnt_q != 2'd0) begin
        acc_q <= acc_q + AccW'(prod_q);
      end
    end else if (state_q == BK_ROOT) begin
      acc_q  <= {acc_q[AccW-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign res_o.valid    = (state_q == BK_OUT);
  assign res_o.min_x    = min_x_q;
  assign res_o.min_y    = min_y_q;
  assign res_o.min_z    = min_z_q;
  assign res_o.max_x    = max_x_q;
  assign res_o.max_y    = max_y_q;
  assign res_o.max_z    = max_z_q;
  assign res_o.center_x = cen_x_q;
  assign res_o.center_y = cen_y_q;
  assign res_o.center_z = cen_z_q;
  // half of the full-diagonal root; always fits, no clamp needed
  assign res_o.radius   = root_q[R-1:1];

endmodule

FILE: hw/rtl/aabb_and_bounding_sphere.sv
// a mesh's box is pushed into the job queue with its last vertex beat, and its result is offered after its finish
// throughput: one vertex beat per cycle while the job queue has room
// the sphere finish runs the squares, then one root bit per cycle, then the result beat
// a two-entry job queue lets the next meshes stream in while a finish runs
// reset: asynchronous active low, empty queue, idle finisher, next vertex starts a mesh
// ----------------------------------------------------------------------------
// aabb_and_bounding_sphere
// Streaming axis-aligned bounding box with bounding sphere per mesh.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aabb_and_bounding_sphere #(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  aabb_vtx_if.sink   vtx_i,
  aabb_res_if.source res_o
);
  import aabb_pkg::*;

  localparam int unsigned JobW = 6 * COORD_WIDTH;

  // front to queue
  logic            push_valid, push_ready;
  logic [JobW-1:0] push_data;
  // queue to back
  logic            job_valid, job_pop;
  logic [JobW-1:0] job_data;

  // front: per-vertex min/max tracking, one beat per cycle while the job queue has room
  aabb_front #(
    .W (COORD_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .vtx_i        (vtx_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // finished boxes wait here for the sphere finisher
  aabb_queue #(
    .DATA_W (JobW),
    .DEPTH  (JOB_QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (job_valid),
    .pop_ready_i  (job_pop),
    .pop_data_o   (job_data)
  );

  // back: centre, squared extents, square root, result beat
  aabb_back #(
    .W (COORD_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_pop_o   (job_pop),
    .job_data_i  (job_data),
    .res_o       (res_o)
  );

endmodule

FILE: dv/aabb_and_bounding_sphere_tb.sv
// ----------------------------------------------------------------------------
// aabb_and_bounding_sphere_tb
// Streams vertex beats into the bounding box and sphere block and checks
// every mesh result against a cycle-free predictor of corners, centre and
// radius, under several patterns of source idling and sink back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aabb_and_bounding_sphere_tb;

  localparam int unsigned COORD_W = 24;
  // tail wait after every predicted result has been checked; keep some slack
  localparam int unsigned TAIL_CYCLES = COORD_W + 7 + 16;
  // long sink hold-off, far longer than one finish, so the job queue fills
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned ITEMS_PER_PHASE = 410;
  localparam longint unsigned LIMIT_CYCLES = 1_000_000;
  localparam int unsigned SHOW_MAX = 10;

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [COORD_W-1:0] RADIUS_SAT = {COORD_W{1'b1}};

  // one vertex beat waiting to be driven
  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   last;
    logic   hold; // source pauses before this beat until no mesh result is pending
  } vertex_t;

  // one mesh result beat
  typedef struct packed {
    coord_t             min_x;
    coord_t             min_y;
    coord_t             min_z;
    coord_t             max_x;
    coord_t             max_y;
    coord_t             max_z;
    coord_t             center_x;
    coord_t             center_y;
    coord_t             center_z;
    logic [COORD_W-1:0] radius;
  } mesh_bounds_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  aabb_vtx_if #(.W(COORD_W)) vtx ();
  aabb_res_if #(.W(COORD_W)) res ();

  aabb_and_bounding_sphere #(
    .COORD_WIDTH(COORD_W)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vtx_i (vtx),
    .res_o (res)
  );

  // testbench-side drive registers, known from time zero
  logic   vtx_valid = 1'b0;
  coord_t vtx_x     = '0;
  coord_t vtx_y     = '0;
  coord_t vtx_z     = '0;
  logic   vtx_last  = 1'b0;
  logic   res_rdy   = 1'b0;

  assign vtx.valid       = vtx_valid;
  assign vtx.pos_x       = vtx_x;
  assign vtx.pos_y       = vtx_y;
  assign vtx.pos_z       = vtx_z;
  assign vtx.last_vertex = vtx_last;
  assign res.ready       = res_rdy;

  // idling knobs, changed per phase
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  logic        holdoff_go   = 1'b0;
  logic        rx_hold      = 1'b0;

  vertex_t      vertex_feed_q [$];
  mesh_bounds_t bounds_due_q  [$];
  int unsigned  err_cnt = 0;

  // predictor state: running box of the open mesh
  coord_t box_lo [3] = '{default: '0};
  coord_t box_hi [3] = '{default: '0};
  logic   mesh_fresh = 1'b1;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // predictor: folds one accepted vertex into the running box; on the last
  // vertex of a mesh it queues corners, floored centre and the radius
  // floor(isqrt(dx^2 + dy^2 + dz^2) / 2), then re-arms for the next mesh
  // --------------------------------------------------------------------------
  function automatic void absorb_vertex(coord_t x, coord_t y, coord_t z, logic last);
    coord_t                  p      [3];
    coord_t                  center [3];
    logic signed [COORD_W:0] wide_lo, wide_hi, span, sum;
    longint unsigned         d, sq_sum, root, trial;
    mesh_bounds_t            b;
    p[0] = x;
    p[1] = y;
    p[2] = z;
    for (int a = 0; a < 3; a++) begin
      // first vertex of a mesh sets both corners
      if (mesh_fresh || p[a] < box_lo[a]) box_lo[a] = p[a];
      if (mesh_fresh || p[a] > box_hi[a]) box_hi[a] = p[a];
    end
    mesh_fresh = 1'b0;
    if (last) begin
      sq_sum = 0;
      for (int a = 0; a < 3; a++) begin
        wide_lo   = box_lo[a];
        wide_hi   = box_hi[a];
        span      = wide_hi - wide_lo;
        sum       = wide_hi + wide_lo;
        d         = span;
        sq_sum   += d * d;
        // arithmetic shift right one of the widened sum
        center[a] = sum[COORD_W:1];
      end
      // bitwise integer root, sum of squares stays below 2^51
      root = 0;
      for (int bitn = 26; bitn >= 0; bitn--) begin
        trial = root | (64'd1 << bitn);
        if (trial * trial <= sq_sum) root = trial;
      end
      root = root >> 1;
      if (root > RADIUS_SAT) root = RADIUS_SAT;
      b.min_x    = box_lo[0];
      b.min_y    = box_lo[1];
      b.min_z    = box_lo[2];
      b.max_x    = box_hi[0];
      b.max_y    = box_hi[1];
      b.max_z    = box_hi[2];
      b.center_x = center[0];
      b.center_y = center[1];
      b.center_z = center[2];
      b.radius   = root[COORD_W-1:0];
      bounds_due_q.insert(bounds_due_q.size(), b);
      mesh_fresh = 1'b1;
    end
  endfunction

  function automatic string bounds_str(mesh_bounds_t b);
    return $sformatf("min (%0d %0d %0d) max (%0d %0d %0d) ctr (%0d %0d %0d) r %0d",
                     b.min_x, b.min_y, b.min_z, b.max_x, b.max_y, b.max_z,
                     b.center_x, b.center_y, b.center_z, b.radius);
  endfunction

  function automatic void queue_vertex(coord_t x, coord_t y, coord_t z, logic last,
                                       logic hold = 1'b0);
    vertex_t v;
    v.x    = x;
    v.y    = y;
    v.z    = z;
    v.last = last;
    v.hold = hold;
    vertex_feed_q.insert(vertex_feed_q.size(), v);
  endfunction

  // half full-range values, a good share near zero, some extremes
  function automatic coord_t rand_coord();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 50) return coord_t'($urandom);
    if (sel < 85) return coord_t'(int'($urandom_range(8191)) - 4096);
    case ($urandom_range(3))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // meshes of random length: mostly short, some medium, a few long
  task automatic queue_random_meshes(int unsigned n_items);
    int unsigned made, len, sel;
    made = 0;
    while (made < n_items) begin
      sel = $urandom_range(99);
      if (sel < 70)      len = $urandom_range(6, 1);
      else if (sel < 95) len = $urandom_range(20, 7);
      else               len = $urandom_range(60, 21);
      for (int unsigned k = 0; k < len; k++)
        queue_vertex(rand_coord(), rand_coord(), rand_coord(), k == len - 1,
                     k == 0 && $urandom_range(39) == 0);
      made += len;
    end
  endtask

  // --------------------------------------------------------------------------
  // vertex driver: predicts on every accepted beat, then offers the next one
  // when the channel is free, honoring random idling and drain pauses
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : vertex_driver
    vertex_t nxt;
    logic    go;
    if (!rst_ni) begin
      vtx_valid <= 1'b0;
      vtx_x     <= '0;
      vtx_y     <= '0;
      vtx_z     <= '0;
      vtx_last  <= 1'b0;
    end else begin
      if (vtx.valid && vtx.ready)
        absorb_vertex(vtx.pos_x, vtx.pos_y, vtx.pos_z, vtx.last_vertex);
      if (!vtx_valid || vtx.ready) begin
        go = vertex_feed_q.size() != 0 && $urandom_range(99) >= tx_idle_pct;
        // drain pause: wait for every pending mesh result
        if (go && vertex_feed_q[0].hold && bounds_due_q.size() != 0) go = 1'b0;
        if (go) begin
          nxt       = vertex_feed_q.pop_front();
          vtx_valid <= 1'b1;
          vtx_x     <= nxt.x;
          vtx_y     <= nxt.y;
          vtx_z     <= nxt.z;
          vtx_last  <= nxt.last;
        end else begin
          vtx_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // result monitor: each accepted result beat against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : bounds_monitor
    mesh_bounds_t got, want;
    if (!rst_ni) begin
      res_rdy <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        got.min_x    = res.min_x;
        got.min_y    = res.min_y;
        got.min_z    = res.min_z;
        got.max_x    = res.max_x;
        got.max_y    = res.max_y;
        got.max_z    = res.max_z;
        got.center_x = res.center_x;
        got.center_y = res.center_y;
        got.center_z = res.center_z;
        got.radius   = res.radius;
        if (bounds_due_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= SHOW_MAX)
            $display("[%0t] unexpected result beat: %s", $realtime, bounds_str(got));
        end else begin
          want = bounds_due_q.pop_front();
          if (got !== want) begin
            err_cnt++;
            if (err_cnt <= SHOW_MAX) begin
              $display("[%0t] result mismatch", $realtime);
              $display("  expected %s", bounds_str(want));
              $display("  actual   %s", bounds_str(got));
            end
          end
        end
      end
      res_rdy <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // long sink hold-off, counted in its own process
  initial begin : sink_holdoff
    wait (holdoff_go);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // watchdog
  initial begin : watchdog
    #(LIMIT_CYCLES * 20);
    $display("DONE: errors detected");
    $finish;
  end

  // --------------------------------------------------------------------------
  // main sequence: reset, directed meshes, then random meshes per idling phase
  // --------------------------------------------------------------------------
  initial begin : main_seq
    int unsigned tx_pct [4];
    int unsigned rx_pct [4];
    // phases: no idling, source idle, sink stalls, both
    tx_pct = '{0, 70, 0, 22};
    rx_pct = '{0, 0, 70, 22};

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // single-vertex meshes at the extremes: corners equal, radius zero
    queue_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
    queue_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
    queue_vertex('0, '0, '0, 1'b1);
    // full-range diagonal, both orders: largest radius
    queue_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
    queue_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
    queue_vertex(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
    queue_vertex(COORD_MIN, COORD_MAX, COORD_MIN, 1'b1);
    // odd negative corner sums exercise the floored centre
    queue_vertex(-24'sd3, -24'sd1, 24'sd5, 1'b0);
    queue_vertex(24'sd0, 24'sd2, -24'sd8, 1'b1);
    // first vertex sits inside the final box
    queue_vertex(24'sd5, 24'sd5, 24'sd5, 1'b0);
    queue_vertex(-24'sd2, 24'sd9, 24'sd3, 1'b0);
    queue_vertex(24'sd7, -24'sd4, 24'sd1, 1'b1);
    // alternating bit patterns
    queue_vertex(24'sh555555, 24'shAAAAAA, 24'sh555555, 1'b0);
    queue_vertex(24'shAAAAAA, 24'sh555555, 24'shAAAAAA, 1'b1);
    // drain pause right after the directed part
    queue_vertex(24'sd1, -24'sd1, 24'sd4096, 1'b1, 1'b1);

    for (int p = 0; p < 4; p++) begin
      while (vertex_feed_q.size() != 0 || vtx_valid) @(posedge clk_i);
      tx_idle_pct  <= tx_pct[p];
      rx_stall_pct <= rx_pct[p];
      // sink holds off while the source streams flat out
      if (p == 0) holdoff_go <= 1'b1;
      @(negedge clk_i);
      queue_vertex(rand_coord(), rand_coord(), rand_coord(), 1'b0, p != 0);
      // short meshes with no pause so the job queue fills under the hold-off
      if (p == 0) repeat (4) queue_vertex(rand_coord(), rand_coord(), rand_coord(), 1'b1);
      queue_random_meshes(ITEMS_PER_PHASE);
    end

    while (vertex_feed_q.size() != 0 || vtx_valid) @(posedge clk_i);
    while (bounds_due_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (err_cnt == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
